/* rtl/core/smbus_word_transaction_sequencer_defines.svh */
// Assertion macros for the SMBus word transaction sequencer.
// No dependencies; included by the modules that carry assertions.
`ifndef SMBUS_WORD_TRANSACTION_SEQUENCER_DEFINES_SVH
`define SMBUS_WORD_TRANSACTION_SEQUENCER_DEFINES_SVH
`ifndef SYNTH
// Implication checked each clock edge, masked while in reset.
`define SWTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Antecedent in one cycle, consequent in the next.
`define SWTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SWTS_ASSERT(lbl, prop, msg)
`define SWTS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* rtl/core/swts_pkg.sv */
// Package for the SMBus word transaction sequencer: codes, phase encoding, structs.
// No dependencies.
package swts_pkg;

  localparam int BAD_EVENT_LIMIT_DEF = 200;
  localparam int CNT_W  = 8;
  localparam int PH_N   = 15;
  localparam int PH_W   = 4;

  typedef enum logic [1:0] {
    OP_START_READ  = 2'd0,
    OP_START_WRITE = 2'd1,
    OP_EVENT       = 2'd2,
    OP_RELEASE     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ACK_NONE    = 2'd0,
    ACK_DISABLE = 2'd1,
    ACK_ENABLE  = 2'd2
  } ack_t;

  typedef enum logic {
    CFG_WRITE_ADDR = 1'b0,
    CFG_READ_ADDR  = 1'b1
  } cfg_idx_t;

  // Bit position of the hot bit equals the external phase code.
  typedef enum logic [PH_N-1:0] {
    PH_IDLE      = 15'h0001,
    PH_WR_ADDR   = 15'h0002,
    PH_COMMAND   = 15'h0004,
    PH_RESTART   = 15'h0008,
    PH_RD_ADDR   = 15'h0010,
    PH_WAIT_RX   = 15'h0020,
    PH_DATA_HI   = 15'h0040,
    PH_DATA_LO   = 15'h0080,
    PH_SEND_PEC  = 15'h0100,
    PH_STOP      = 15'h0200,
    PH_WR_DONE   = 15'h0400,
    PH_RX_HI     = 15'h0800,
    PH_RX_LO     = 15'h1000,
    PH_RX_PEC    = 15'h2000,
    PH_RD_DONE   = 15'h4000
  } phase_t;

  typedef struct packed {
    phase_t       phase;
    logic         rd_dir;
    logic [7:0]   cmd;
    logic [15:0]  word;
    logic [7:0]   pec;
    logic [CNT_W-1:0] bad_cnt;
  } state_t;

  typedef struct packed {
    op_t         operation;
    logic [7:0]  command_byte;
    logic [15:0] write_word;
    logic        ev_mode_select;
    logic        ev_tx_selected;
    logic        ev_byte_sent;
    logic        ev_rx_selected;
    logic        ev_byte_received;
    logic [7:0]  rx_byte;
  } item_t;

  typedef struct packed {
    logic        accepted;
    logic [PH_W-1:0] phase;
    logic        send_byte;
    logic [7:0]  tx_byte;
    logic        gen_start;
    logic        gen_stop;
    ack_t        ack_change;
    logic [15:0] read_word;
    logic [7:0]  received_pec;
    logic        reset_request;
  } result_t;

  function automatic logic [PH_W-1:0] phase_code(input phase_t ph);
    logic [PH_W-1:0] code;
    code = '0;
    for (int i = 0; i < PH_N; i++) begin
      if (ph[i]) code = code | PH_W'(i);
    end
    return code;
  endfunction

endpackage

/* rtl/core/swts_if.sv */
// Valid/ready channel interfaces for the SMBus word transaction sequencer.
// No dependencies.
interface swts_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  command_byte;
  logic [15:0] write_word;
  logic        ev_mode_select;
  logic        ev_tx_selected;
  logic        ev_byte_sent;
  logic        ev_rx_selected;
  logic        ev_byte_received;
  logic [7:0]  rx_byte;

  modport source (output valid, operation, command_byte, write_word, ev_mode_select,
                  ev_tx_selected, ev_byte_sent, ev_rx_selected, ev_byte_received,
                  rx_byte, input ready);
  modport sink (input valid, operation, command_byte, write_word, ev_mode_select,
                ev_tx_selected, ev_byte_sent, ev_rx_selected, ev_byte_received,
                rx_byte, output ready);
endinterface

interface swts_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [3:0]  phase;
  logic        send_byte;
  logic [7:0]  tx_byte;
  logic        gen_start;
  logic        gen_stop;
  logic [1:0]  ack_change;
  logic [15:0] read_word;
  logic [7:0]  received_pec;
  logic        reset_request;

  modport source (output valid, accepted, phase, send_byte, tx_byte, gen_start, gen_stop,
                  ack_change, read_word, received_pec, reset_request, input ready);
  modport sink (input valid, accepted, phase, send_byte, tx_byte, gen_start, gen_stop,
                ack_change, read_word, received_pec, reset_request, output ready);
endinterface

/* rtl/core/swts_step.sv */
// Next-state and result logic for one transaction of the sequencer.
// Depends on swts_pkg.
module swts_step #(
  parameter int BAD_EVENT_LIMIT = swts_pkg::BAD_EVENT_LIMIT_DEF
) (
  input  swts_pkg::state_t  st,
  input  swts_pkg::item_t   item,
  input  logic [7:0]        wr_addr,
  input  logic [7:0]        rd_addr,
  output swts_pkg::state_t  st_nxt,
  output swts_pkg::result_t res
);
  import swts_pkg::*;

  localparam logic [CNT_W-1:0] LIMIT = CNT_W'(BAD_EVENT_LIMIT);
  localparam logic [CNT_W-1:0] SAT   = '1;

  logic       done;
  logic       seen;
  logic       send;
  logic [7:0] tx;
  logic       gstart;
  logic       gstop;
  ack_t       ack;
  logic       acc;
  logic       rreq;

  always_comb begin
    st_nxt = st;
    done   = 1'b0;
    seen   = 1'b0;
    send   = 1'b0;
    tx     = '0;
    gstart = 1'b0;
    gstop  = 1'b0;
    ack    = ACK_NONE;
    acc    = 1'b1;
    rreq   = 1'b0;

    unique case (item.operation)
      OP_START_READ, OP_START_WRITE: begin
        if (st.phase != PH_IDLE) begin
          acc = 1'b0;
        end else begin
          st_nxt.cmd = item.command_byte;
          if (item.operation == OP_START_READ) begin
            st_nxt.word   = '0;
            st_nxt.pec    = '0;
            st_nxt.rd_dir = 1'b1;
          end else begin
            st_nxt.word   = item.write_word;
            st_nxt.rd_dir = 1'b0;
          end
          st_nxt.phase = PH_WR_ADDR;
          gstart       = 1'b1;
        end
      end
      OP_RELEASE: begin
        st_nxt.phase = PH_IDLE;
      end
      OP_EVENT: begin
        // Flags in priority order; a set flag that fits no phase clears the count.
        if (item.ev_mode_select) begin
          if (st.phase == PH_WR_ADDR) begin
            st_nxt.phase = PH_COMMAND; send = 1'b1; tx = wr_addr; done = 1'b1;
          end else if (st.phase == PH_RD_ADDR) begin
            st_nxt.phase = PH_WAIT_RX; send = 1'b1; tx = rd_addr; done = 1'b1;
          end else begin
            st_nxt.bad_cnt = '0; seen = 1'b1;
          end
        end
        if (!done && item.ev_tx_selected) begin
          if (st.phase == PH_COMMAND) begin
            st_nxt.phase = st.rd_dir ? PH_RESTART : PH_DATA_HI;
            send = 1'b1; tx = st.cmd; done = 1'b1;
          end else begin
            st_nxt.bad_cnt = '0; seen = 1'b1;
          end
        end
        if (!done && item.ev_byte_sent) begin
          if (st.phase == PH_RESTART) begin
            st_nxt.phase = PH_RD_ADDR; gstart = 1'b1; done = 1'b1;
          end else if (st.phase == PH_DATA_HI) begin
            st_nxt.phase = PH_DATA_LO; send = 1'b1; tx = st.word[15:8]; done = 1'b1;
          end else if (st.phase == PH_DATA_LO) begin
            st_nxt.phase = PH_STOP; send = 1'b1; tx = st.word[7:0]; done = 1'b1;
          end else if (st.phase == PH_SEND_PEC) begin
            st_nxt.phase = PH_STOP; send = 1'b1; tx = st.pec; done = 1'b1;
          end else if (st.phase == PH_STOP) begin
            st_nxt.phase = PH_WR_DONE; gstop = 1'b1; done = 1'b1;
          end else begin
            st_nxt.bad_cnt = '0; seen = 1'b1;
          end
        end
        if (!done && item.ev_rx_selected) begin
          if (st.phase == PH_WAIT_RX) begin
            st_nxt.phase = PH_RX_HI; done = 1'b1;
          end else begin
            st_nxt.bad_cnt = '0; seen = 1'b1;
          end
        end
        if (!done && item.ev_byte_received) begin
          if (st.phase == PH_RX_HI) begin
            st_nxt.word = {8'h00, item.rx_byte}; st_nxt.phase = PH_RX_LO; done = 1'b1;
          end else if (st.phase == PH_RX_LO) begin
            st_nxt.word  = {st.word[7:0], item.rx_byte};
            st_nxt.phase = PH_RX_PEC; ack = ACK_DISABLE; gstop = 1'b1; done = 1'b1;
          end else if (st.phase == PH_RX_PEC) begin
            st_nxt.pec = item.rx_byte; ack = ACK_ENABLE; st_nxt.phase = PH_RD_DONE;
            done = 1'b1;
          end else begin
            st_nxt.bad_cnt = '0; seen = 1'b1;
          end
        end
        if (!done) begin
          if (!seen && st.bad_cnt != SAT) st_nxt.bad_cnt = st.bad_cnt + 1'b1;
          rreq = (st_nxt.bad_cnt > LIMIT);
        end
      end
      default: begin
        acc = 1'b1;
      end
    endcase
  end

  always_comb begin
    res.accepted      = acc;
    res.phase         = phase_code(st_nxt.phase);
    res.send_byte     = send;
    res.tx_byte       = tx;
    res.gen_start     = gstart;
    res.gen_stop      = gstop;
    res.ack_change    = ack;
    res.read_word     = st_nxt.word;
    res.received_pec  = st_nxt.pec;
    res.reset_request = rreq;
  end

endmodule

/* rtl/core/smbus_word_transaction_sequencer.sv */
// A result is registered and appears in the cycle after its transaction is accepted.
// Throughput: one transaction per cycle; the single result register sets it, and
// in_ch.ready stays high while that register is empty or being drained.
// Reset (rst_n low, synchronous): phase idle, all state and the event count
// cleared, write address 0, read address 1, result register emptied.
// Depends on swts_pkg, swts_if, swts_step and the defines header.
`include "smbus_word_transaction_sequencer_defines.svh"

module smbus_word_transaction_sequencer #(
  parameter int BAD_EVENT_LIMIT = swts_pkg::BAD_EVENT_LIMIT_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  swts_in_if.sink         in_ch,
  swts_out_if.source      out_ch,
  input  logic            cfg_wr_en,
  input  logic            cfg_index,
  input  logic [7:0]      cfg_wdata
);
  import swts_pkg::*;

  // Configuration registers: address bytes for the two address phases.
  logic [7:0] wr_addr_r;
  logic [7:0] rd_addr_r;

  // Sequencer state and the result register.
  state_t  st_r;
  state_t  st_nxt;
  result_t res_r;
  result_t res_nxt;
  logic    out_valid_r;

  item_t   item;
  logic    in_fire;
  logic    out_fire;

  // Accept a new transaction whenever the result register is free this cycle.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_valid_r && out_ch.ready;

  always_comb begin
    item.operation        = op_t'(in_ch.operation);
    item.command_byte     = in_ch.command_byte;
    item.write_word       = in_ch.write_word;
    item.ev_mode_select   = in_ch.ev_mode_select;
    item.ev_tx_selected   = in_ch.ev_tx_selected;
    item.ev_byte_sent     = in_ch.ev_byte_sent;
    item.ev_rx_selected   = in_ch.ev_rx_selected;
    item.ev_byte_received = in_ch.ev_byte_received;
    item.rx_byte          = in_ch.rx_byte;
  end

  swts_step #(
    .BAD_EVENT_LIMIT (BAD_EVENT_LIMIT)
  ) u_step (
    .st      (st_r),
    .item    (item),
    .wr_addr (wr_addr_r),
    .rd_addr (rd_addr_r),
    .st_nxt  (st_nxt),
    .res     (res_nxt)
  );

  // Configuration writes; the user must issue them only while idle, the block does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_addr_r <= 8'h00;
      rd_addr_r <= 8'h01;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_WRITE_ADDR: wr_addr_r <= cfg_wdata;
        CFG_READ_ADDR:  rd_addr_r <= cfg_wdata;
        default:        wr_addr_r <= wr_addr_r;
      endcase
    end
  end

  // Advance the sequencer state on every accepted transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase   <= PH_IDLE;
      st_r.rd_dir  <= 1'b0;
      st_r.cmd     <= '0;
      st_r.word    <= '0;
      st_r.pec     <= '0;
      st_r.bad_cnt <= '0;
    end else if (in_fire) begin
      st_r <= st_nxt;
    end
  end

  // Result register: load on accept, drop the valid flag once drained.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.accepted      = res_r.accepted;
  assign out_ch.phase         = res_r.phase;
  assign out_ch.send_byte     = res_r.send_byte;
  assign out_ch.tx_byte       = res_r.tx_byte;
  assign out_ch.gen_start     = res_r.gen_start;
  assign out_ch.gen_stop      = res_r.gen_stop;
  assign out_ch.ack_change    = res_r.ack_change;
  assign out_ch.read_word     = res_r.read_word;
  assign out_ch.received_pec  = res_r.received_pec;
  assign out_ch.reset_request = res_r.reset_request;

  // Phase register holds exactly one hot bit.
  `SWTS_ASSERT(a_phase_onehot, $onehot(st_r.phase), "phase register not one-hot")
  // A pending reset request implies the stored count is past the limit.
  `SWTS_ASSERT(a_rreq_count,
    (out_valid_r && res_r.reset_request) |-> (st_r.bad_cnt > CNT_W'(BAD_EVENT_LIMIT)),
    "reset request without enough bad events")
  // A start while busy is rejected and leaves the phase untouched.
  `SWTS_ASSERT_NEXT(a_busy_reject,
    in_fire && st_r.phase != PH_IDLE &&
      (item.operation == OP_START_READ || item.operation == OP_START_WRITE),
    !res_r.accepted && $stable(st_r.phase),
    "busy start not rejected")
  // Reported phase matches the phase register it was taken from.
  `SWTS_ASSERT(a_phase_match, out_valid_r |-> (res_r.phase == phase_code(st_r.phase)),
    "reported phase differs from phase register")

endmodule

/* bench/smbus_word_transaction_sequencer_tb.sv */
// Self-checking bench for the SMBus word transaction sequencer: directed and random
// transactions against an in-bench prediction of every result, compared field by field.
// Depends on swts_pkg, the swts_in_if / swts_out_if interfaces and the sequencer RTL.
module smbus_word_transaction_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import swts_pkg::*;

  // External phase codes as they appear on out_ch.phase.
  typedef enum logic [3:0] {
    SEQ_IDLE     = 4'd0,
    SEQ_WR_ADDR  = 4'd1,
    SEQ_COMMAND  = 4'd2,
    SEQ_RESTART  = 4'd3,
    SEQ_RD_ADDR  = 4'd4,
    SEQ_WAIT_RX  = 4'd5,
    SEQ_DATA_HI  = 4'd6,
    SEQ_DATA_LO  = 4'd7,
    SEQ_SEND_PEC = 4'd8,
    SEQ_STOP     = 4'd9,
    SEQ_WR_DONE  = 4'd10,
    SEQ_RX_HI    = 4'd11,
    SEQ_RX_LO    = 4'd12,
    SEQ_RX_PEC   = 4'd13,
    SEQ_RD_DONE  = 4'd14
  } seq_phase_t;

  // Event flag sets, in field order: mode select, tx selected, byte sent,
  // rx selected, byte received.
  localparam logic [4:0] EV_NONE = 5'b00000;
  localparam logic [4:0] EV_MS   = 5'b10000;
  localparam logic [4:0] EV_TX   = 5'b01000;
  localparam logic [4:0] EV_BS   = 5'b00100;
  localparam logic [4:0] EV_RX   = 5'b00010;
  localparam logic [4:0] EV_BR   = 5'b00001;
  localparam logic [4:0] EV_ALL  = 5'b11111;

  localparam int RUN_LIMIT   = 200000;
  localparam int LONG_HOLD   = 80;
  localparam int MAX_PRINTED = 40;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_wr_en;
  logic       cfg_index;
  logic [7:0] cfg_wdata;

  swts_in_if  in_if ();
  swts_out_if out_if ();

  smbus_word_transaction_sequencer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mirror of the sequencer state, held at its reset values until the first
  // transaction is accepted.
  seq_phase_t  seq_phase   = SEQ_IDLE;
  logic        read_dir    = 1'b0;
  logic [7:0]  cmd_latch   = 8'h00;
  logic [15:0] word_latch  = 16'h0000;
  logic [7:0]  pec_latch   = 8'h00;
  logic [7:0]  stray_count = 8'h00;
  logic [7:0]  write_addr  = 8'h00;
  logic [7:0]  read_addr   = 8'h01;

  // Bus actions predicted for accepted transactions, oldest first.
  result_t predicted_actions[$];

  // Idling controls: sender gaps, receiver stalls, and a one-shot long hold-off.
  bit tx_gaps   = 1'b0;
  bit rx_stalls = 1'b0;
  bit hold_req  = 1'b0;

  int error_count    = 0;
  int result_count   = 0;
  int txn_count      = 0;
  int reads_done     = 0;
  int writes_done    = 0;
  int busy_refusals  = 0;
  int reset_requests = 0;
  int cycle_count    = 0;

  // Step the mirrored sequencer by one transaction and return the bus action
  // it must produce.
  function automatic result_t advance_sequencer(item_t it);
    result_t act;
    logic    acted;
    logic    flagged;
    act          = '0;
    act.accepted = 1'b1;
    acted        = 1'b0;
    flagged      = 1'b0;
    case (it.operation)
      OP_START_READ, OP_START_WRITE: begin
        if (seq_phase != SEQ_IDLE) begin
          act.accepted = 1'b0;
        end else begin
          cmd_latch = it.command_byte;
          if (it.operation == OP_START_READ) begin
            word_latch = 16'h0000;
            pec_latch  = 8'h00;
            read_dir   = 1'b1;
          end else begin
            word_latch = it.write_word;
            read_dir   = 1'b0;
          end
          seq_phase     = SEQ_WR_ADDR;
          act.gen_start = 1'b1;
        end
      end
      OP_RELEASE: begin
        seq_phase = SEQ_IDLE;
      end
      default: begin
        // Walk the flags in field order; the first one that fits the phase acts, and
        // any set flag checked before it that does not fit just clears the stray count.
        if (it.ev_mode_select) begin
          if (seq_phase == SEQ_WR_ADDR) begin
            seq_phase = SEQ_COMMAND; act.send_byte = 1'b1; act.tx_byte = write_addr;
            acted = 1'b1;
          end else if (seq_phase == SEQ_RD_ADDR) begin
            seq_phase = SEQ_WAIT_RX; act.send_byte = 1'b1; act.tx_byte = read_addr;
            acted = 1'b1;
          end else begin
            stray_count = 8'h00; flagged = 1'b1;
          end
        end
        if (!acted && it.ev_tx_selected) begin
          if (seq_phase == SEQ_COMMAND) begin
            seq_phase     = read_dir ? SEQ_RESTART : SEQ_DATA_HI;
            act.send_byte = 1'b1;
            act.tx_byte   = cmd_latch;
            acted         = 1'b1;
          end else begin
            stray_count = 8'h00; flagged = 1'b1;
          end
        end
        if (!acted && it.ev_byte_sent) begin
          acted = 1'b1;
          case (seq_phase)
            SEQ_RESTART: begin
              seq_phase = SEQ_RD_ADDR; act.gen_start = 1'b1;
            end
            SEQ_DATA_HI: begin
              seq_phase = SEQ_DATA_LO; act.send_byte = 1'b1; act.tx_byte = word_latch[15:8];
            end
            SEQ_DATA_LO: begin
              seq_phase = SEQ_STOP; act.send_byte = 1'b1; act.tx_byte = word_latch[7:0];
            end
            SEQ_SEND_PEC: begin
              seq_phase = SEQ_STOP; act.send_byte = 1'b1; act.tx_byte = pec_latch;
            end
            SEQ_STOP: begin
              seq_phase = SEQ_WR_DONE; act.gen_stop = 1'b1;
            end
            default: begin
              acted = 1'b0; stray_count = 8'h00; flagged = 1'b1;
            end
          endcase
        end
        if (!acted && it.ev_rx_selected) begin
          if (seq_phase == SEQ_WAIT_RX) begin
            seq_phase = SEQ_RX_HI; acted = 1'b1;
          end else begin
            stray_count = 8'h00; flagged = 1'b1;
          end
        end
        if (!acted && it.ev_byte_received) begin
          acted = 1'b1;
          case (seq_phase)
            SEQ_RX_HI: begin
              word_latch = {8'h00, it.rx_byte}; seq_phase = SEQ_RX_LO;
            end
            SEQ_RX_LO: begin
              // Shift the high byte up; drop ACK ahead of the stop.
              word_latch     = {word_latch[7:0], it.rx_byte};
              seq_phase      = SEQ_RX_PEC;
              act.ack_change = ACK_DISABLE;
              act.gen_stop   = 1'b1;
            end
            SEQ_RX_PEC: begin
              pec_latch = it.rx_byte; act.ack_change = ACK_ENABLE; seq_phase = SEQ_RD_DONE;
            end
            default: begin
              acted = 1'b0; stray_count = 8'h00; flagged = 1'b1;
            end
          endcase
        end
        if (!acted) begin
          // Count events with no flag set, saturating at the top of the counter.
          if (!flagged && stray_count != 8'hff) stray_count = stray_count + 8'd1;
          if (stray_count > BAD_EVENT_LIMIT_DEF) act.reset_request = 1'b1;
        end
      end
    endcase
    act.phase        = seq_phase;
    act.read_word    = word_latch;
    act.received_pec = pec_latch;
    return act;
  endfunction

  function automatic item_t event_item(logic [4:0] flags, logic [7:0] rx);
    item_t it;
    it           = '0;
    it.operation = OP_EVENT;
    {it.ev_mode_select, it.ev_tx_selected, it.ev_byte_sent, it.ev_rx_selected,
     it.ev_byte_received} = flags;
    it.rx_byte   = rx;
    return it;
  endfunction

  function automatic item_t request_item(op_t op, logic [7:0] cmd, logic [15:0] word);
    item_t it;
    it              = '0;
    it.operation    = op;
    it.command_byte = cmd;
    it.write_word   = word;
    return it;
  endfunction

  // Choose the next transaction from the mirrored phase: mostly the event that
  // moves the sequence on, with random payload, some stray flags, some noise and
  // some early releases.
  function automatic item_t pick_next_item();
    item_t       it;
    logic [63:0] raw;
    int          roll;
    raw  = {$urandom(), $urandom()};
    it   = item_t'(raw[$bits(item_t)-1:0]);
    roll = $urandom_range(0, 99);
    if (roll < 10) return it;
    if (roll < 13) begin
      it.operation = OP_RELEASE;
      return it;
    end
    it.operation = OP_EVENT;
    if ($urandom_range(0, 3) != 0) begin
      {it.ev_mode_select, it.ev_tx_selected, it.ev_byte_sent, it.ev_rx_selected,
       it.ev_byte_received} = EV_NONE;
    end
    case (seq_phase)
      SEQ_IDLE:                   it.operation = $urandom_range(0, 1) ? OP_START_WRITE
                                                                       : OP_START_READ;
      SEQ_WR_ADDR, SEQ_RD_ADDR:   it.ev_mode_select = 1'b1;
      SEQ_COMMAND:                it.ev_tx_selected = 1'b1;
      SEQ_RESTART, SEQ_DATA_HI, SEQ_DATA_LO, SEQ_SEND_PEC, SEQ_STOP:
                                  it.ev_byte_sent = 1'b1;
      SEQ_WAIT_RX:                it.ev_rx_selected = 1'b1;
      SEQ_RX_HI, SEQ_RX_LO, SEQ_RX_PEC:
                                  it.ev_byte_received = 1'b1;
      default: begin
        // Finished: mostly release, now and then try a start that must be refused.
        it.operation = ($urandom_range(0, 4) == 0) ? op_t'($urandom_range(0, 1)) : OP_RELEASE;
      end
    endcase
    return it;
  endfunction

  task automatic drive_item(item_t it);
    in_if.operation        <= it.operation;
    in_if.command_byte     <= it.command_byte;
    in_if.write_word       <= it.write_word;
    in_if.ev_mode_select   <= it.ev_mode_select;
    in_if.ev_tx_selected   <= it.ev_tx_selected;
    in_if.ev_byte_sent     <= it.ev_byte_sent;
    in_if.ev_rx_selected   <= it.ev_rx_selected;
    in_if.ev_byte_received <= it.ev_byte_received;
    in_if.rx_byte          <= it.rx_byte;
  endtask

  // Offer one transaction, hold it until taken, then predict its bus action.
  // Valid is left high on return so back-to-back transactions need no toggle.
  task automatic send_txn(item_t it);
    int      gap;
    result_t act;
    gap = (tx_gaps && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    drive_item(it);
    in_if.valid <= 1'b1;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    act = advance_sequencer(it);
    predicted_actions.push_back(act);
    txn_count++;
    if (!act.accepted) busy_refusals++;
    if (act.reset_request) reset_requests++;
    if (act.gen_stop && act.phase == SEQ_WR_DONE) writes_done++;
    if (act.ack_change == ACK_ENABLE) reads_done++;
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (predicted_actions.size() != 0) @(posedge clk);
  endtask

  // Write both address registers once the sequencer has delivered everything.
  task automatic program_addresses(logic [7:0] wr_byte, logic [7:0] rd_byte);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_WRITE_ADDR;
    cfg_wdata <= wr_byte;
    @(posedge clk);
    write_addr = wr_byte;
    cfg_index <= CFG_READ_ADDR;
    cfg_wdata <= rd_byte;
    @(posedge clk);
    read_addr = rd_byte;
    cfg_wr_en <= 1'b0;
  endtask

  task automatic report_mismatch(string msg);
    error_count++;
    // Cap the log; every mismatch still counts.
    if (error_count <= MAX_PRINTED) $display("Mismatch at result %0d: %s", result_count, msg);
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
  endtask

  // Compare every result taken from the sequencer with the oldest prediction.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (predicted_actions.size() == 0) begin
        report_mismatch("result with no transaction outstanding");
      end else begin
        want = predicted_actions.pop_front();
        check_field("accepted",      out_if.accepted,      want.accepted);
        check_field("phase",         out_if.phase,         want.phase);
        check_field("send_byte",     out_if.send_byte,     want.send_byte);
        check_field("tx_byte",       out_if.tx_byte,       want.tx_byte);
        check_field("gen_start",     out_if.gen_start,     want.gen_start);
        check_field("gen_stop",      out_if.gen_stop,      want.gen_stop);
        check_field("ack_change",    out_if.ack_change,    want.ack_change);
        check_field("read_word",     out_if.read_word,     want.read_word);
        check_field("received_pec",  out_if.received_pec,  want.received_pec);
        check_field("reset_request", out_if.reset_request, want.reset_request);
      end
      result_count++;
    end
  end

  // Receiver: random short stalls, plus one long hold-off on request so that
  // the result register fills and the input side backs up.
  initial begin
    int hold_left;
    hold_left = 0;
    out_if.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD;
      end else if (rx_stalls && $urandom_range(0, 4) == 0) begin
        hold_left = $urandom_range(1, 7);
      end
      out_if.ready <= (hold_left == 0);
    end
  end

  // Stop a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("Cycle limit reached with %0d results outstanding", predicted_actions.size());
      $display("FAIL");
      $finish;
    end
  end

  // Full read with the reset addresses: extreme received bytes, a start refused
  // mid-transaction and another refused once the read is finished.
  task automatic test_read_word();
    send_txn(request_item(OP_START_READ, 8'hff, 16'hffff));
    send_txn(request_item(OP_START_WRITE, 8'h12, 16'h3456));
    send_txn(event_item(EV_MS, 8'h00));
    send_txn(event_item(EV_TX, 8'h00));
    send_txn(event_item(EV_BS, 8'h00));
    send_txn(event_item(EV_MS, 8'h00));
    send_txn(event_item(EV_RX, 8'h00));
    send_txn(event_item(EV_BR, 8'hff));
    send_txn(event_item(EV_BR, 8'h00));
    send_txn(event_item(EV_BR, 8'ha5));
    send_txn(request_item(OP_START_READ, 8'h00, 16'h0000));
    send_txn(request_item(OP_RELEASE, 8'h00, 16'h0000));
  endtask

  // Full write of an all-ones word with an all-zero command.
  task automatic test_write_word();
    send_txn(request_item(OP_START_WRITE, 8'h00, 16'hffff));
    send_txn(event_item(EV_MS, 8'h00));
    send_txn(event_item(EV_TX, 8'h00));
    send_txn(event_item(EV_BS, 8'h00));
    send_txn(event_item(EV_BS, 8'h00));
    send_txn(event_item(EV_BS, 8'h00));
    send_txn(request_item(OP_RELEASE, 8'h00, 16'h0000));
  endtask

  // Empty and crowded events: no flags counts, unmatched flags clear the count,
  // and with every flag set the first matching one wins.
  task automatic test_event_corners();
    send_txn(event_item(EV_NONE, 8'h00));
    send_txn(event_item(EV_ALL, 8'hff));
    send_txn(request_item(OP_RELEASE, 8'h00, 16'h0000));
    send_txn(request_item(OP_START_READ, 8'h5a, 16'h0000));
    send_txn(event_item(EV_ALL, 8'h3c));
    send_txn(event_item(EV_MS | EV_TX, 8'h00));
    send_txn(request_item(OP_RELEASE, 8'h00, 16'h0000));
  endtask

  // Run the stray-event count past the reset-request limit and into saturation,
  // then clear it with an unmatched flag.
  task automatic test_stray_event_overflow();
    repeat (260) send_txn(event_item(EV_NONE, 8'($urandom_range(0, 255))));
    send_txn(event_item(EV_BR, 8'h00));
    send_txn(event_item(EV_NONE, 8'h00));
  endtask

  // Hold the receiver off for a long stretch while the sender keeps offering.
  task automatic test_backpressure();
    bit saved_gaps;
    saved_gaps = tx_gaps;
    tx_gaps    = 1'b0;
    hold_req   = 1'b1;
    repeat (24) send_txn(pick_next_item());
    tx_gaps = saved_gaps;
  endtask

  task automatic test_random_traffic(int count, bit idling);
    tx_gaps   = idling;
    rx_stalls = idling;
    repeat (count) send_txn(pick_next_item());
  endtask

  initial begin
    // Hold every input at a known value through reset.
    rst_n       <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_index   <= CFG_WRITE_ADDR;
    cfg_wdata   <= 8'h00;
    in_if.valid <= 1'b0;
    drive_item('0);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    test_read_word();
    program_addresses(8'hff, 8'h00);
    test_write_word();
    test_event_corners();
    test_stray_event_overflow();
    test_backpressure();

    // Random traffic across several address settings; idle-free at the end.
    program_addresses(8'h00, 8'hff);
    test_random_traffic(28, 1'b1);
    program_addresses(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    test_random_traffic(28, 1'b1);
    program_addresses(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    test_random_traffic(28, 1'b0);
    program_addresses(8'hff, 8'hff);
    test_random_traffic(28, 1'b1);
    program_addresses(8'h00, 8'h01);
    test_random_traffic(28, 1'b0);

    drain_results();
    repeat (4) @(posedge clk);
    $display("Covered %0d transactions under seven address settings: %0d word reads, %0d %s",
             txn_count, reads_done, writes_done, "word writes");
    $display("completed, %0d starts refused while busy, %0d reset requests, %0d mismatches.",
             busy_refusals, reset_requests, error_count);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
